// File: rtl/core/bse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse_pkg: shared types, constants and helpers of the escape-time unit
// Fixed-point format, token layout carried around the cell ring, and the
// saturation helpers used by every iteration cell.
// ----------------------------------------------------------------------------
package bse_pkg;

	// Coordinate format: signed, FRAC_BITS fraction bits
	localparam int COORD_BITS = 32;
	localparam int FRAC_BITS  = 28;

	// Full product of two magnitudes, and a saturated product magnitude
	localparam int PROD_BITS = 2 * COORD_BITS;
	localparam int MAG_BITS  = COORD_BITS - 1;

	// Register widths
	localparam int RAD_BITS      = 31;
	localparam int COUNT_BITS    = 16;
	localparam int CFG_DATA_BITS = 31;
	localparam int CFG_ADDR_BITS = 1;

	// Compare width for |z|^2 against the radius, wide enough for either side
	localparam int CMP_BITS = COORD_BITS + RAD_BITS;

	// Stream word widths, whole bytes
	localparam int IN_DATA_BITS  = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((COUNT_BITS + 1 + 7) / 8) * 8;
	localparam int OUT_PAD_BITS  = OUT_DATA_BITS - COUNT_BITS - 1;

	// Number of iteration cells in the ring
	localparam int NUM_CELLS = 4;

	// Register indexes
	localparam logic [CFG_ADDR_BITS-1:0] REG_ESCAPE_RADIUS_SQ = 1'b0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_ITERATION_LIMIT  = 1'b1;

	// Reset values
	localparam logic [RAD_BITS-1:0]   RADIUS_RESET = RAD_BITS'(1 << 30);
	localparam logic [COUNT_BITS-1:0] LIMIT_RESET  = COUNT_BITS'(100);

	typedef struct packed {
		logic [RAD_BITS-1:0]   radius;
		logic [COUNT_BITS-1:0] limit;
	} cfg_t;

	// State of one point as it travels around the ring
	typedef struct packed {
		logic                         done;
		logic                         hit;
		logic [COUNT_BITS-1:0]        count;
		logic signed [COORD_BITS-1:0] zx;
		logic signed [COORD_BITS-1:0] zy;
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
	} tok_t;

	function automatic logic [COORD_BITS-1:0] coord_mag(input logic signed [COORD_BITS-1:0] v);
		logic [COORD_BITS-1:0] r;
		if (v[COORD_BITS-1]) begin
			r = ~v + COORD_BITS'(1);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Saturate an already shifted product to the largest positive coordinate
	function automatic logic [MAG_BITS-1:0] sat_mag(input logic [PROD_BITS-1:0] v);
		logic [MAG_BITS-1:0] r;
		if (|v[PROD_BITS-1:MAG_BITS]) begin
			r = '1;
		end else begin
			r = v[MAG_BITS-1:0];
		end
		return r;
	endfunction

	// Clamp a two-bit-extended sum to the coordinate range
	function automatic logic signed [COORD_BITS-1:0] sat_coord(
		input logic signed [COORD_BITS+1:0] v
	);
		logic signed [COORD_BITS-1:0] r;
		if (v[COORD_BITS+1:COORD_BITS-1] == 3'b000 ||
		    v[COORD_BITS+1:COORD_BITS-1] == 3'b111) begin
			r = v[COORD_BITS-1:0];
		end else if (v[COORD_BITS+1]) begin
			r = {1'b1, {(COORD_BITS-1){1'b0}}};
		end else begin
			r = {1'b0, {(COORD_BITS-1){1'b1}}};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/bse_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse_cell: one Burning Ship iteration cell
// Three stages: magnitudes, products, then escape test and update.
// A finished token passes through unchanged.
// ----------------------------------------------------------------------------
module bse_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bse_pkg::cfg_t cfg,
	input  wire logic          in_valid,
	input  wire bse_pkg::tok_t tok_in,
	output logic               out_valid,
	output bse_pkg::tok_t      tok_out
);

	logic                                valid_s1, valid_s2, valid_q;
	bse_pkg::tok_t                       tok_s1, tok_s2, tok_q, tok_nxt;
	logic [bse_pkg::COORD_BITS-1:0]      mx_s1, my_s1;
	logic [bse_pkg::PROD_BITS-1:0]       px_s2, py_s2, pxy_s2;
	logic [bse_pkg::MAG_BITS-1:0]        sx, sy, dbl;
	logic [bse_pkg::COORD_BITS-1:0]      m;
	logic                                escape, at_limit;
	logic signed [bse_pkg::COORD_BITS+1:0] nx_w, ny_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_q  <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		tok_s1 <= tok_in;
		mx_s1  <= bse_pkg::coord_mag(tok_in.zx);
		my_s1  <= bse_pkg::coord_mag(tok_in.zy);
		tok_s2 <= tok_s1;
		px_s2  <= mx_s1 * mx_s1;
		py_s2  <= my_s1 * my_s1;
		pxy_s2 <= mx_s1 * my_s1;
		tok_q  <= tok_nxt;
	end

	// Doubled cross product: shift one bit less
	assign sx  = bse_pkg::sat_mag(px_s2 >> bse_pkg::FRAC_BITS);
	assign sy  = bse_pkg::sat_mag(py_s2 >> bse_pkg::FRAC_BITS);
	assign dbl = bse_pkg::sat_mag(pxy_s2 >> (bse_pkg::FRAC_BITS - 1));

	assign m        = {1'b0, sx} + {1'b0, sy};
	assign escape   = {{bse_pkg::RAD_BITS{1'b0}}, m} >=
	                  {{bse_pkg::COORD_BITS{1'b0}}, cfg.radius};
	assign at_limit = tok_s2.count == cfg.limit;

	assign nx_w = $signed({3'b000, sx}) - $signed({3'b000, sy})
	            + $signed({{2{tok_s2.cx[bse_pkg::COORD_BITS-1]}}, tok_s2.cx});
	assign ny_w = $signed({3'b000, dbl})
	            + $signed({{2{tok_s2.cy[bse_pkg::COORD_BITS-1]}}, tok_s2.cy});

	// Limit test comes before the escape test
	always_comb begin
		tok_nxt = tok_s2;
		if (!tok_s2.done) begin
			if (at_limit) begin
				tok_nxt.done = 1'b1;
				tok_nxt.hit  = 1'b1;
			end else if (escape) begin
				tok_nxt.done = 1'b1;
				tok_nxt.hit  = 1'b0;
			end else begin
				tok_nxt.zx    = bse_pkg::sat_coord(nx_w);
				tok_nxt.zy    = bse_pkg::sat_coord(ny_w);
				tok_nxt.count = tok_s2.count + bse_pkg::COUNT_BITS'(1);
			end
		end
	end

	assign out_valid = valid_q;
	assign tok_out   = tok_q;

endmodule
`default_nettype wire

// File: rtl/core/burning_ship_escape_time.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// burning_ship_escape_time: Burning Ship escape-time counter
// Counts the steps a point c survives under the Burning Ship map, using a
// ring of pipelined iteration cells.
// ----------------------------------------------------------------------------
// One point at a time circulates around a ring of NUM_CELLS (4) identical
// cells; each cell does one step of the map through its magnitude, product
// and escape-test-and-update stages, so one lap of the ring covers four
// evaluations. A point that stops after n steps needs n+1 evaluations (one
// for a zero limit) and is handed from the last cell to the output register
// at the end of its lap, where the result word becomes valid. A finished
// token that comes round while the output register still holds an untaken
// word laps again unchanged. The next point is taken once the current
// result has moved into that register, so a waiting result does not block
// it. Configuration is written through a plain write port and must only
// change while no point is in flight.
// ----------------------------------------------------------------------------
module burning_ship_escape_time (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration
	input  wire logic                               cfg_we,
	input  wire logic [bse_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
	input  wire logic [bse_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	// point in
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [bse_pkg::IN_DATA_BITS-1:0]   s_tdata,  // c_real, c_imag
	// result out
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [bse_pkg::OUT_DATA_BITS-1:0]       m_tdata   // iteration_count, hit_limit, pad
);

	localparam int CB = bse_pkg::COORD_BITS;
	localparam int NC = bse_pkg::NUM_CELLS;

	bse_pkg::cfg_t                       cfg_q;
	logic                                busy_q;
	logic                                out_valid_q;
	logic [bse_pkg::COUNT_BITS-1:0]      count_q;
	logic                                hit_q;

	logic                                s_accept, capture;
	bse_pkg::tok_t                       new_tok;
	logic          cell_in_valid  [NC];
	bse_pkg::tok_t cell_in_tok    [NC];
	logic          cell_out_valid [NC];
	bse_pkg::tok_t cell_out_tok   [NC];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius <= bse_pkg::RADIUS_RESET;
			cfg_q.limit  <= bse_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				bse_pkg::REG_ESCAPE_RADIUS_SQ: begin
					cfg_q.radius <= cfg_wdata[bse_pkg::RAD_BITS-1:0];
				end
				bse_pkg::REG_ITERATION_LIMIT: begin
					cfg_q.limit <= cfg_wdata[bse_pkg::COUNT_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Take a new point only with the ring empty
	assign s_tready = !busy_q;
	assign s_accept = s_tvalid && s_tready;

	// Drain a finished token at the ring's closing point when the output
	// register is free; otherwise let it lap again unchanged
	assign capture = cell_out_valid[NC-1] && cell_out_tok[NC-1].done &&
	                 (!out_valid_q || m_tready);

	always_comb begin
		new_tok       = '0;
		new_tok.cx    = s_tdata[CB-1:0];
		new_tok.cy    = s_tdata[2*CB-1:CB];
		new_tok.zx    = s_tdata[CB-1:0];
		new_tok.zy    = s_tdata[2*CB-1:CB];
	end

	assign cell_in_valid[0] = s_accept || (cell_out_valid[NC-1] && !capture);
	assign cell_in_tok[0]   = s_accept ? new_tok : cell_out_tok[NC-1];

	for (genvar i = 1; i < NC; i++) begin : g_link
		assign cell_in_valid[i] = cell_out_valid[i-1];
		assign cell_in_tok[i]   = cell_out_tok[i-1];
	end

	for (genvar i = 0; i < NC; i++) begin : g_cell
		bse_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cfg       (cfg_q),
			.in_valid  (cell_in_valid[i]),
			.tok_in    (cell_in_tok[i]),
			.out_valid (cell_out_valid[i]),
			.tok_out   (cell_out_tok[i])
		);
	end

	// Busy from accept until the result is captured
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_accept) begin
				busy_q <= 1'b1;
			end else if (capture) begin
				busy_q <= 1'b0;
			end
			if (capture) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the result word until taken
	always_ff @(posedge clk) begin
		if (capture) begin
			count_q <= cell_out_tok[NC-1].count;
			hit_q   <= cell_out_tok[NC-1].hit;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{bse_pkg::OUT_PAD_BITS{1'b0}}, hit_q, count_q};

endmodule
`default_nettype wire
